// ===== rtl/core/hfi_pkg.sv =====
package hfi_pkg;

    // Default sine quantization: table steps per quarter turn, as a power of two.
    localparam int SINE_BITS_DEF = 8;

    // Opcodes of an input beat.
    localparam logic [1:0] OPC_PWM    = 2'd0;
    localparam logic [1:0] OPC_UPDATE = 2'd1;
    localparam logic [1:0] OPC_BUS    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IND_OFS = 2'd0;
    localparam logic [1:0] CFG_HYST    = 2'd1;
    localparam logic [1:0] CFG_SPU     = 2'd2;
    localparam logic [1:0] CFG_INJ_V   = 2'd3;

    // Reset values.
    localparam logic [15:0] SPU_RESET = 16'd16;
    localparam logic [16:0] BUS_RESET = 17'd65536;

    // Quarter-sine polynomial coefficients (Q15).
    localparam logic [15:0] SIN_COEF_A = 16'd51472;
    localparam logic [14:0] SIN_COEF_B = 15'd21024;
    localparam logic [11:0] SIN_COEF_C = 12'd2320;

    // Iterations of the shared divider.
    localparam int DIV_STEPS = 32;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD_IN,
        DP_PROJ_A,
        DP_PROJ_B,
        DP_PWM,
        DP_MISC,
        DP_DIV_LD_ACC,
        DP_DIV_STEP,
        DP_ANGLE,
        DP_SINE,
        DP_DIV_LD_DUTY,
        DP_DUTY_SAT,
        DP_INJ,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op      op;
        logic [4:0]  step;
        logic        idle;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        update_go;
    } t_dp_stat;

endpackage

// ===== rtl/core/hfi_ctrl.sv =====
module hfi_ctrl
    import hfi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_DECODE    = 14'b00000000000010,
        S_PROJ_A    = 14'b00000000000100,
        S_PROJ_B    = 14'b00000000001000,
        S_PWM       = 14'b00000000010000,
        S_MISC      = 14'b00000000100000,
        S_CHECK     = 14'b00000001000000,
        S_DIV_ACC   = 14'b00000010000000,
        S_ANGLE     = 14'b00000100000000,
        S_SINE      = 14'b00001000000000,
        S_DUTY_LD   = 14'b00010000000000,
        S_DIV_DUTY  = 14'b00100000000000,
        S_DUTY_SAT  = 14'b01000000000000,
        S_INJ       = 14'b10000000000000
    } t_state;

    localparam logic [4:0] DIV_LAST  = 5'(DIV_STEPS - 1);
    localparam logic [4:0] SINE_LAST = 5'd9;
    localparam logic [4:0] INJ_LAST  = 5'd2;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       r_out_pend, n_out_pend;
    logic       out_free;

    // The result register can be loaded when empty or being drained this cycle.
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        n_out_pend = r_out_pend;
        o_cmd.op   = DP_NONE;
        o_cmd.step = r_cnt;
        o_cmd.idle = (r_state == S_IDLE) && !r_out_pend;
        case (r_state)
            S_IDLE: begin
                if (r_out_pend) begin
                    // A finished result waits for the output register.
                    if (out_free) begin
                        o_cmd.op   = DP_OUT;
                        n_out_pend = 1'b0;
                    end
                end else if (i_in_valid) begin
                    o_cmd.op = DP_LOAD_IN;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.opcode == OPC_PWM) begin
                    n_state = S_PROJ_A;
                end else if (i_stat.opcode == OPC_UPDATE) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = S_MISC;
                end
            end
            S_PROJ_A: begin
                o_cmd.op = DP_PROJ_A;
                n_state  = S_PROJ_B;
            end
            S_PROJ_B: begin
                o_cmd.op = DP_PROJ_B;
                n_state  = S_PWM;
            end
            S_PWM: begin
                o_cmd.op   = DP_PWM;
                n_state    = S_IDLE;
                n_out_pend = 1'b1;
            end
            S_MISC: begin
                o_cmd.op   = DP_MISC;
                n_state    = S_IDLE;
                n_out_pend = 1'b1;
            end
            S_CHECK: begin
                if (i_stat.update_go) begin
                    o_cmd.op = DP_DIV_LD_ACC;
                    n_state  = S_DIV_ACC;
                end else begin
                    n_state    = S_IDLE;
                    n_out_pend = 1'b1;
                end
            end
            S_DIV_ACC: begin
                o_cmd.op = DP_DIV_STEP;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                o_cmd.op = DP_ANGLE;
                n_state  = S_SINE;
            end
            S_SINE: begin
                o_cmd.op = DP_SINE;
                if (r_cnt == SINE_LAST) begin
                    n_state = S_DUTY_LD;
                end
            end
            S_DUTY_LD: begin
                o_cmd.op = DP_DIV_LD_DUTY;
                n_state  = S_DIV_DUTY;
            end
            S_DIV_DUTY: begin
                o_cmd.op = DP_DIV_STEP;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DUTY_SAT;
                end
            end
            S_DUTY_SAT: begin
                o_cmd.op = DP_DUTY_SAT;
                n_state  = S_INJ;
            end
            S_INJ: begin
                o_cmd.op = DP_INJ;
                if (r_cnt == INJ_LAST) begin
                    n_state    = S_IDLE;
                    n_out_pend = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Step counter restarts on every state change.
    assign n_cnt = (n_state != r_state) ? 5'd0 : r_cnt + 5'd1;

    // Output valid: set on a load, cleared when the beat is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.op == DP_OUT) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 5'd0;
            r_out_valid <= 1'b0;
            r_out_pend  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_out_pend  <= n_out_pend;
        end
    end

    assign o_in_stall  = !((r_state == S_IDLE) && !r_out_pend);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/hfi_dpath.sv =====
module hfi_dpath
    import hfi_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic [1:0]         i_opcode,
    input  logic signed [15:0] i_v_alpha_in,
    input  logic signed [15:0] i_v_beta_in,
    input  logic signed [15:0] i_i_alpha,
    input  logic signed [15:0] i_i_beta,
    input  logic signed [15:0] i_i_q,
    input  logic [16:0]        i_bus_volts,
    output logic signed [15:0] o_v_alpha_out,
    output logic signed [15:0] o_v_beta_out,
    output logic signed [15:0] o_angle_out,
    output logic signed [15:0] o_speed_out,
    output logic               o_ready_res
);

    // Mask keeping the table index bits of a quarter-turn angle.
    localparam logic [13:0] L_IDX_MASK =
        14'((16'h3FFF >> (14 - SINE_TABLE_BITS)) << (14 - SINE_TABLE_BITS));

    // Captured input beat.
    logic [1:0]         r_op;
    logic signed [15:0] r_va, r_vb, r_ia, r_ib, r_iq;
    logic [16:0]        r_bus;

    // Configuration registers.
    logic signed [15:0] r_ind_ofs;
    logic [14:0]        r_hyst;
    logic [15:0]        r_spu;
    logic [14:0]        r_inj_v;

    // Estimator state.
    logic [1:0]         r_phase;
    logic               r_pol, r_ready;
    logic signed [31:0] r_prior, r_acc;
    logic [15:0]        r_cnt;
    logic [15:0]        r_est, r_last, r_angle;
    logic signed [15:0] r_speed, r_cos, r_sin, r_inj_a, r_inj_b;
    logic [16:0]        r_bus_div;

    // Work registers.
    logic signed [35:0] r_prod;
    logic [16:0]        r_x2;
    logic [16:0]        r_div_rem, r_div_dvs;
    logic [31:0]        r_div_quo;
    logic               r_acc_neg;
    logic [14:0]        r_duty;
    logic signed [15:0] r_va_res, r_vb_res;

    // Result register.
    logic signed [15:0] r_o_va, r_o_vb, r_o_angle, r_o_speed;
    logic               r_o_ready;

    // Shared multiplier.
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;

    // Sine step decode.
    logic               sel_cos;
    logic [2:0]         sub;
    logic [15:0]        sin_u;
    logic [16:0]        x_base, x_eff;
    logic [14:0]        sin_t;
    logic [15:0]        sin_t2;
    logic [16:0]        sin_s;
    logic signed [15:0] sin_val;

    // Divider step.
    logic [17:0]        rem_sh;
    logic               div_ge;
    logic [16:0]        rem_new;

    // Injection step.
    logic [16:0]        iq_mag;
    logic               ready_new, pol_new;
    logic signed [32:0] dsub;
    logic signed [32:0] di;
    logic signed [33:0] term, term_s;
    logic signed [16:0] va_sum, vb_sum;
    logic signed [15:0] va_sat, vb_sat;

    // Angle update.
    logic signed [16:0] spd_bias, spd_q;
    logic [15:0]        half16, est1, est2, diff16;
    logic signed [19:0] spd_sum, spd_sh;

    // Sine operand: angle of the axis, a quarter turn on for cosine.
    always_comb begin
        sel_cos = (i_cmd.step >= 5'd5);
        sub     = sel_cos ? 3'(i_cmd.step - 5'd5) : i_cmd.step[2:0];
        sin_u   = r_est + (r_pol ? 16'hE000 : 16'h2000) + (sel_cos ? 16'h4000 : 16'h0000);
        x_base  = {2'b00, sin_u[13:0] & L_IDX_MASK, 1'b0};
        x_eff   = sin_u[14] ? (17'd32768 - x_base) : x_base;
        sin_t   = SIN_COEF_B - r_prod[29:15];
        sin_t2  = SIN_COEF_A - r_prod[30:15];
        sin_s   = r_prod[31:15];
        // The clamped magnitude still takes the sign of the half turn.
        if (sin_s > 17'd32767) begin
            sin_val = sin_u[15] ? -16'sd32767 : 16'sd32767;
        end else begin
            sin_val = sin_u[15] ? -$signed(sin_s[15:0]) : $signed(sin_s[15:0]);
        end
    end

    // Operand selection for the multiplier.
    always_comb begin
        mul_a = 18'sd0;
        mul_b = 18'sd0;
        case (i_cmd.op)
            DP_PROJ_A: begin
                mul_a = 18'(r_cos);
                mul_b = 18'(r_ia);
            end
            DP_PROJ_B: begin
                mul_a = 18'(r_sin);
                mul_b = 18'(r_ib);
            end
            DP_SINE: begin
                case (sub)
                    3'd0: begin
                        mul_a = $signed({1'b0, x_eff});
                        mul_b = $signed({1'b0, x_eff});
                    end
                    3'd1: begin
                        mul_a = $signed({1'b0, r_prod[31:15]});
                        mul_b = $signed({6'd0, SIN_COEF_C});
                    end
                    3'd2: begin
                        mul_a = $signed({1'b0, r_x2});
                        mul_b = $signed({3'd0, sin_t});
                    end
                    3'd3: begin
                        mul_a = $signed({1'b0, x_eff});
                        mul_b = $signed({2'd0, sin_t2});
                    end
                    default: begin
                        mul_a = 18'sd0;
                        mul_b = 18'sd0;
                    end
                endcase
            end
            DP_INJ: begin
                mul_a = $signed({3'd0, r_duty});
                mul_b = (i_cmd.step == 5'd0) ? 18'(r_cos) : 18'(r_sin);
            end
            default: begin
                mul_a = 18'sd0;
                mul_b = 18'sd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Restoring divider step, one quotient bit a cycle.
    always_comb begin
        rem_sh  = {r_div_rem, r_div_quo[31]};
        div_ge  = (rem_sh >= {1'b0, r_div_dvs});
        rem_new = div_ge ? 17'(rem_sh - {1'b0, r_div_dvs}) : rem_sh[16:0];
    end

    // Injection step: demodulation and voltage injection.
    always_comb begin
        iq_mag    = r_iq[15] ? 17'(-{r_iq[15], r_iq}) : {1'b0, r_iq};
        ready_new = (iq_mag > {2'b00, r_hyst});
        pol_new   = ready_new ? r_iq[15] : r_pol;
        dsub      = 33'($signed(r_prod[31:0])) - 33'(r_prior);
        di        = dsub >>> 8;
        term      = 34'(di) - 34'(r_ind_ofs);
        term_s    = pol_new ? -term : term;
        if (r_phase[1]) begin
            va_sum = 17'(r_va) + 17'(r_inj_a);
            vb_sum = 17'(r_vb) + 17'(r_inj_b);
        end else begin
            va_sum = 17'(r_va) - 17'(r_inj_a);
            vb_sum = 17'(r_vb) - 17'(r_inj_b);
        end
        if (va_sum > 17'sd32767) begin
            va_sat = 16'sd32767;
        end else if (va_sum < -17'sd32768) begin
            va_sat = -16'sd32768;
        end else begin
            va_sat = va_sum[15:0];
        end
        if (vb_sum > 17'sd32767) begin
            vb_sat = 16'sd32767;
        end else if (vb_sum < -17'sd32768) begin
            vb_sat = -16'sd32768;
        end else begin
            vb_sat = vb_sum[15:0];
        end
    end

    // Angle advance and speed filter.
    always_comb begin
        spd_bias = 17'(r_speed) + (r_speed[15] ? 17'sd255 : 17'sd0);
        spd_q    = spd_bias >>> 8;
        half16   = r_div_quo[16:1];
        est1     = r_est + spd_q[15:0];
        est2     = r_acc_neg ? (est1 + half16) : (est1 - half16);
        diff16   = r_last - est2;
        spd_sum  = 20'($signed(diff16)) + (20'(r_speed) <<< 3) - 20'(r_speed);
        spd_sh   = spd_sum >>> 3;
    end

    assign o_stat.opcode    = r_op;
    assign o_stat.update_go = (r_cnt > r_spu);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ind_ofs <= 16'sd0;
            r_hyst    <= 15'd0;
            r_spu     <= SPU_RESET;
            r_inj_v   <= 15'd0;
        end else if (i_cfg_valid && i_cmd.idle) begin
            case (i_cfg_index)
                CFG_IND_OFS: r_ind_ofs <= i_cfg_data;
                CFG_HYST:    r_hyst    <= i_cfg_data[14:0];
                CFG_SPU:     r_spu     <= i_cfg_data;
                CFG_INJ_V:   r_inj_v   <= i_cfg_data[14:0];
                default:     r_spu     <= r_spu;
            endcase
        end
    end

    // Estimator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 2'd0;
            r_pol     <= 1'b0;
            r_ready   <= 1'b0;
            r_prior   <= 32'sd0;
            r_acc     <= 32'sd0;
            r_cnt     <= 16'd0;
            r_est     <= 16'd0;
            r_last    <= 16'd0;
            r_angle   <= 16'd0;
            r_speed   <= 16'sd0;
            r_cos     <= 16'sd0;
            r_sin     <= 16'sd0;
            r_inj_a   <= 16'sd0;
            r_inj_b   <= 16'sd0;
            r_bus_div <= BUS_RESET;
        end else begin
            case (i_cmd.op)
                DP_PWM: begin
                    if (r_phase == 2'd0) begin
                        r_ready <= ready_new;
                        r_pol   <= pol_new;
                        r_acc   <= r_acc + term_s[31:0];
                        if (r_cnt != 16'hFFFF) begin
                            r_cnt <= r_cnt + 16'd1;
                        end
                    end else if (r_phase == 2'd2) begin
                        r_prior <= r_prod[31:0];
                    end
                    r_phase <= r_phase + 2'd1;
                end
                DP_MISC: begin
                    if (r_op == OPC_BUS) begin
                        r_bus_div <= (r_bus == 17'd0) ? 17'd1 : r_bus;
                    end
                end
                DP_ANGLE: begin
                    r_est   <= est2;
                    r_last  <= est2;
                    r_angle <= -est2;
                    r_speed <= spd_sh[15:0];
                    r_acc   <= 32'sd0;
                    r_cnt   <= 16'd0;
                end
                DP_SINE: begin
                    if (sub == 3'd4) begin
                        if (sel_cos) begin
                            r_cos <= sin_val;
                        end else begin
                            r_sin <= sin_val;
                        end
                    end
                end
                DP_INJ: begin
                    if (i_cmd.step == 5'd1) begin
                        r_inj_a <= r_prod[30:15];
                    end else if (i_cmd.step == 5'd2) begin
                        r_inj_b <= r_prod[30:15];
                    end
                end
                default: begin
                    r_phase <= r_phase;
                end
            endcase
        end
    end

    // Input capture, multiplier product, divider and results.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD_IN: begin
                r_op     <= i_opcode;
                r_va     <= i_v_alpha_in;
                r_vb     <= i_v_beta_in;
                r_ia     <= i_i_alpha;
                r_ib     <= i_i_beta;
                r_iq     <= i_i_q;
                r_bus    <= i_bus_volts;
                r_va_res <= 16'sd0;
                r_vb_res <= 16'sd0;
            end
            DP_PROJ_A: begin
                r_prod <= mul_p;
            end
            DP_PROJ_B: begin
                r_prod <= r_prod + mul_p;
            end
            DP_PWM: begin
                r_va_res <= va_sat;
                r_vb_res <= vb_sat;
            end
            DP_DIV_LD_ACC: begin
                r_acc_neg <= r_acc[31];
                r_div_quo <= r_acc[31] ? 32'(-r_acc) : r_acc;
                r_div_rem <= 17'd0;
                r_div_dvs <= {1'b0, r_cnt};
            end
            DP_DIV_LD_DUTY: begin
                r_div_quo <= {1'b0, r_inj_v, 16'd0};
                r_div_rem <= 17'd0;
                r_div_dvs <= r_bus_div;
            end
            DP_DIV_STEP: begin
                r_div_rem <= rem_new;
                r_div_quo <= {r_div_quo[30:0], div_ge};
            end
            DP_SINE: begin
                r_prod <= mul_p;
                if (sub == 3'd1) begin
                    r_x2 <= r_prod[31:15];
                end
            end
            DP_DUTY_SAT: begin
                r_duty <= (|r_div_quo[31:15]) ? 15'h7FFF : r_div_quo[14:0];
            end
            DP_INJ: begin
                r_prod <= mul_p;
            end
            DP_OUT: begin
                r_o_va    <= r_va_res;
                r_o_vb    <= r_vb_res;
                r_o_angle <= r_angle;
                r_o_speed <= r_speed + 16'sd8;
                r_o_ready <= r_ready;
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    assign o_v_alpha_out = r_o_va;
    assign o_v_beta_out  = r_o_vb;
    assign o_angle_out   = r_o_angle;
    assign o_speed_out   = r_o_speed;
    assign o_ready_res   = r_o_ready;

endmodule

// ===== rtl/core/hfi_rotor_angle_estimator_unit.sv =====
// A PWM beat passes decode, two projection steps and the PWM step; a bus-voltage beat passes
// decode and the misc step, an update not above the sample threshold decode and the check step.
// Throughput: one beat in flight; a full update runs two passes of the shared serial divider
// and the shared multiplier running the sine polynomial.
// Reset is synchronous, active low, and restores all estimator and configuration state.
module hfi_rotor_angle_estimator_unit
    import hfi_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [15:0] i_v_alpha_in,
    input  logic signed [15:0] i_v_beta_in,
    input  logic signed [15:0] i_i_alpha,
    input  logic signed [15:0] i_i_beta,
    input  logic signed [15:0] i_i_q,
    input  logic [16:0]        i_bus_volts,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_v_alpha_out,
    output logic signed [15:0] o_v_beta_out,
    output logic signed [15:0] o_angle_out,
    output logic signed [15:0] o_speed_out,
    output logic               o_ready_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer.
    hfi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Arithmetic and state.
    hfi_dpath #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_v_alpha_in  (i_v_alpha_in),
        .i_v_beta_in   (i_v_beta_in),
        .i_i_alpha     (i_i_alpha),
        .i_i_beta      (i_i_beta),
        .i_i_q         (i_i_q),
        .i_bus_volts   (i_bus_volts),
        .o_v_alpha_out (o_v_alpha_out),
        .o_v_beta_out  (o_v_beta_out),
        .o_angle_out   (o_angle_out),
        .o_speed_out   (o_speed_out),
        .o_ready_res   (o_ready_res)
    );

    // Configuration is taken while no beat is in progress.
    assign o_cfg_ready = cmd.idle;

endmodule
